FILE: hw/rtl/asla_pkg.sv
// ----------------------------------------------------------------------------
// asla_pkg
// Shared widths, constants and codes for the ADC sensor linearize/average block.
// ----------------------------------------------------------------------------
package asla_pkg;

  localparam int DIV_W  = 32;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 16;
  localparam int CODE_W = 10;
  localparam int MV_W   = 13;
  localparam int AVG_W  = 9;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 16;

  localparam int unsigned MV_NUM    = 488;
  localparam int unsigned MV_DEN    = 100;
  localparam int unsigned SUPPLY_MV = 5000;
  localparam int unsigned R_SCALE   = 100;
  localparam int unsigned LIGHT_NUM = 50000;
  localparam int unsigned LIGHT_DIV = 100;
  localparam int unsigned TEMP_DIV  = 10;
  localparam int unsigned AVG_MAX   = 500;

  localparam logic MODE_LIGHT = 1'b0;
  localparam logic MODE_TEMP  = 1'b1;
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef logic [DIV_W-1:0] div_word_t;

endpackage

FILE: hw/rtl/asla_div.sv
// ----------------------------------------------------------------------------
// asla_div
// Shared restoring divider: one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module asla_div
  import asla_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/adc_sensor_linearize_average_unit.sv
// ----------------------------------------------------------------------------
// adc_sensor_linearize_average_unit
// Linearizes ADC samples and returns block averages on request.
// ----------------------------------------------------------------------------
// One 32-step restoring divider is shared by every step, so the input takes
// one word at a time: a temperature sample needs one division, a light
// sample up to three (millivolts, resistance, then 50000/resistance), an
// update two (sum/count, then the scale-down) and an update with no
// samples none. The result sits in an output register, so the next word is
// taken while it waits. s_axis_tuser carries op (0 sample, 1 update);
// m_axis_tuser flags an update that found no samples.
module adc_sensor_linearize_average_unit
  import asla_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,      // sensor_mode
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [9:0] adc_code
  input  logic                   s_axis_tuser,   // [0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [8:0] average
  output logic                   m_axis_tuser    // [0] empty_res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MV   = 3'd1;
  localparam logic [2:0] ST_RES  = 3'd2;
  localparam logic [2:0] ST_LUX  = 3'd3;
  localparam logic [2:0] ST_AVG  = 3'd4;
  localparam logic [2:0] ST_SCL  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]       state;
  logic             sensor_mode;
  logic [SUM_W-1:0] running_sum;
  logic [CNT_W-1:0] sample_count;
  logic             div_start;
  div_word_t        div_dvd;
  div_word_t        div_dvs;
  logic             div_done;
  div_word_t        div_quo;
  logic [AVG_W-1:0] res_avg;
  logic             res_empty;
  logic [AVG_W-1:0] out_avg;
  logic             out_empty;

  logic             s_fire;
  logic             out_free;
  logic [MV_W-1:0]  mv;
  logic [CODE_W-1:0] code;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign mv            = div_quo[MV_W-1:0];
  assign code          = s_axis_tdata[CODE_W-1:0];

  asla_div #(
    .W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sensor_mode   <= MODE_LIGHT;
      running_sum   <= '0;
      sample_count  <= '0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        sensor_mode <= cfg_wdata;
      end
      if ((state == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser == OP_SAMPLE) begin
              // drop a sample at full count
              if (sample_count != '1) begin
                sample_count <= sample_count + 1'b1;
                div_start    <= 1'b1;
                state        <= ST_MV;
              end
            end else if (sample_count == '0) begin
              running_sum <= '0;
              state       <= ST_DONE;
            end else begin
              div_start <= 1'b1;
              state     <= ST_AVG;
            end
          end
        end
        ST_MV: begin
          if (div_done) begin
            if (sensor_mode == MODE_TEMP) begin
              running_sum <= running_sum + SUM_W'(mv);
              state       <= ST_IDLE;
            end else if (mv <= MV_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              div_start <= 1'b1;
              state     <= ST_RES;
            end
          end
        end
        ST_RES: begin
          if (div_done) begin
            if (div_quo == '0) begin
              running_sum <= running_sum + SUM_W'(LIGHT_NUM);
              state       <= ST_IDLE;
            end else begin
              div_start <= 1'b1;
              state     <= ST_LUX;
            end
          end
        end
        ST_LUX: begin
          if (div_done) begin
            running_sum <= running_sum + SUM_W'(div_quo);
            state       <= ST_IDLE;
          end
        end
        ST_AVG: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= ST_SCL;
          end
        end
        ST_SCL: begin
          if (div_done) begin
            running_sum  <= '0;
            sample_count <= '0;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tuser == OP_SAMPLE) begin
          div_dvd <= div_word_t'(code) * div_word_t'(MV_NUM);
          div_dvs <= div_word_t'(MV_DEN);
        end else begin
          div_dvd <= div_word_t'(running_sum);
          div_dvs <= div_word_t'(sample_count);
        end
        res_avg   <= '0;
        res_empty <= 1'b1;
      end
      ST_MV: begin
        div_dvd <= div_word_t'(R_SCALE) * div_word_t'(MV_W'(SUPPLY_MV) - mv);
        div_dvs <= div_word_t'(mv);
      end
      ST_RES: begin
        div_dvd <= div_word_t'(LIGHT_NUM);
        div_dvs <= div_quo;
      end
      ST_AVG: begin
        div_dvd <= div_quo;
        div_dvs <= (sensor_mode == MODE_TEMP) ? div_word_t'(TEMP_DIV)
                                              : div_word_t'(LIGHT_DIV);
      end
      ST_SCL: begin
        res_avg   <= (div_quo > div_word_t'(AVG_MAX)) ? AVG_W'(AVG_MAX)
                                                      : div_quo[AVG_W-1:0];
        res_empty <= 1'b0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_avg   <= res_avg;
          out_empty <= res_empty;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {{(TDATA_OUT_W - AVG_W){1'b0}}, out_avg};
  assign m_axis_tuser = out_empty;

endmodule
